// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk with arst_n as reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked at every rising edge of clk outside reset.
`define AST_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Same, with a message of the caller's choosing.
`define AST_CLK_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`else
`define AST_CLK(label, prop)
`define AST_CLK_MSG(label, prop, msg)
`endif
`endif

// ===== src/fdre_pkg.sv =====
// ---------------------------------------------------------------------------
// fdre_pkg
// Types, codes and the CRC16 byte update shared by the download reply engine.
// ---------------------------------------------------------------------------
package fdre_pkg;

	// Input word commands.
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// Result actions.
	localparam logic [2:0] ACT_NOTIFY  = 3'd0;
	localparam logic [2:0] ACT_CHUNK   = 3'd1;
	localparam logic [2:0] ACT_DONE    = 3'd2;
	localparam logic [2:0] ACT_CRC_ERR = 3'd3;
	localparam logic [2:0] ACT_DEV_ERR = 3'd4;
	localparam logic [2:0] ACT_DROP    = 3'd5;

	// Reply frame bytes.
	localparam logic [7:0] FRM_ADDR       = 8'h01;
	localparam logic [7:0] FRM_NOTIFY_ACK = 8'h41;
	localparam logic [7:0] FRM_CHUNK_ACK  = 8'h42;
	localparam logic [7:0] FRM_ERR_A      = 8'hC1;
	localparam logic [7:0] FRM_ERR_B      = 8'hC2;

	localparam logic [3:0]  FRM_MAX_BYTES = 4'd11;
	localparam logic [3:0]  FRM_MIN_CHECK = 4'd5;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;

	// Events raised by the frame receiver for one received byte.
	typedef struct packed {
		logic       drop;
		logic       crc_err;
		logic       notify_ack;
		logic       chunk_ack;
		logic       dev_err;
		logic [7:0] code;
	} frame_evt_t;

	// Modbus-RTU CRC16, one byte, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Number of bytes covered by the CRC for a given reply command.
	function automatic logic [3:0] body_len(input logic [7:0] c);
		logic [3:0] n;
		if (c == FRM_NOTIFY_ACK) begin
			n = 4'd4;
		end else if (c == FRM_CHUNK_ACK) begin
			n = 4'd9;
		end else begin
			n = 4'd3;
		end
		return n;
	endfunction

	function automatic logic known_cmd(input logic [7:0] c);
		return (c == FRM_NOTIFY_ACK) || (c == FRM_CHUNK_ACK) ||
			(c == FRM_ERR_A) || (c == FRM_ERR_B);
	endfunction

endpackage

// ===== src/fdre_frame_rx.sv =====
// ---------------------------------------------------------------------------
// Reply frame receiver
// Assembles reply frames byte by byte, runs the CRC and flags frame events.
// ---------------------------------------------------------------------------
module fdre_frame_rx (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic                    clear,
	input  logic [7:0]              rx_byte,
	input  logic                    active,
	output fdre_pkg::frame_evt_t    evt
);

	logic [3:0]  count_q, count_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  cmd_q, code_q, prev_q;
	logic [7:0]  cmd_now;
	logic [3:0]  cnt_inc, need;
	logic [15:0] rx_crc;

	// The command byte, the error code and the previous byte are the only stored
	// bytes read back; the CRC low byte is always the byte just before the last one.
	always_comb begin
		cmd_now = (count_q == 4'd1) ? rx_byte : cmd_q;
		cnt_inc = count_q + 4'd1;
		need    = fdre_pkg::body_len(cmd_q) + 4'd2;
		rx_crc  = {rx_byte, prev_q};
		count_d = count_q;
		crc_d   = crc_q;
		evt     = '0;
		evt.code = code_q;
		if (clear) begin
			count_d = '0;
			crc_d   = fdre_pkg::CRC_INIT;
		end else if (step) begin
			if (count_q == 4'd0 && rx_byte != fdre_pkg::FRM_ADDR) begin
				evt.drop = 1'b1;
			end else if (count_q >= fdre_pkg::FRM_MAX_BYTES) begin
				evt.drop = 1'b1;
				count_d  = '0;
				crc_d    = fdre_pkg::CRC_INIT;
			end else begin
				count_d = cnt_inc;
				if (count_q < 4'd2 || count_q < fdre_pkg::body_len(cmd_now)) begin
					crc_d = fdre_pkg::crc16_byte(crc_q, rx_byte);
				end
				if (cnt_inc >= fdre_pkg::FRM_MIN_CHECK) begin
					if (!fdre_pkg::known_cmd(cmd_q) || !active) begin
						evt.drop = 1'b1;
						count_d  = '0;
						crc_d    = fdre_pkg::CRC_INIT;
					end else if (cnt_inc == need) begin
						count_d = '0;
						crc_d   = fdre_pkg::CRC_INIT;
						if (rx_crc != crc_q) begin
							evt.crc_err = 1'b1;
						end else if (cmd_q == fdre_pkg::FRM_NOTIFY_ACK) begin
							evt.notify_ack = 1'b1;
						end else if (cmd_q == fdre_pkg::FRM_CHUNK_ACK) begin
							evt.chunk_ack = 1'b1;
						end else begin
							evt.dev_err = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= fdre_pkg::CRC_INIT;
		end else begin
			count_q <= count_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !clear) begin
			prev_q <= rx_byte;
			if (count_q == 4'd1) begin
				cmd_q <= rx_byte;
			end
			if (count_q == 4'd2) begin
				code_q <= rx_byte;
			end
		end
	end

endmodule

// ===== src/file_download_response_engine_unit.sv =====
// ---------------------------------------------------------------------------
// File download response engine
// Sender side of a chunked file download: turns received reply bytes and
// start, stop and retry-tick events into the next action to take.
// ---------------------------------------------------------------------------
// Each input word is either a received serial byte or an event. Words are
// captured in an input register, handled in one pass of short logic (frame
// assembly, a one-byte CRC16 update, and one subtract for the chunk size)
// and written to a result register, so the block takes one word per clock
// cycle while the output register does not hold it. A word moves from the
// input register to the result register once that register is free or
// being drained, and its result stays on the outputs until taken. Words
// that cause no result (most received bytes, start, stop, an unarmed tick)
// pass through without producing an output word. The output register only
// holds the engine when it is full and out_ready is low. There is no
// clearing pass after reset. The offset of the following chunk is kept in a
// register of its own so that a chunk acknowledge needs only a single
// subtract against the file length.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module file_download_response_engine_unit #(
	parameter int CHUNK_BYTES = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [23:0] chunk_offset,
	output logic [7:0]  chunk_length,
	output logic [7:0]  device_code
);

	// Input register stage.
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;

	// Download state. The next offset always equals the send offset plus one
	// chunk, modulo 2^25.
	logic [23:0] file_len_q;
	logic        active_q, armed_q;
	logic [24:0] offset_q, next_off_q;

	// Result register.
	logic        out_valid_q;
	logic [2:0]  action_q;
	logic [23:0] offset_out_q;
	logic [7:0]  length_q, code_q;

	fdre_pkg::frame_evt_t evt;
	logic        is_byte, is_start;
	logic [24:0] base_off;
	logic [25:0] remain;
	logic        past_end;
	logic [7:0]  len_calc;
	logic        emit;
	logic [2:0]  act_d;
	logic [23:0] off_d;
	logic [7:0]  len_d, code_d;

	// The stage moves whenever the result register is free or being drained.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign is_byte  = valid_s1 && cmd_s1 == fdre_pkg::CMD_BYTE;
	assign is_start = valid_s1 && cmd_s1 == fdre_pkg::CMD_START;

	fdre_frame_rx u_frame_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1 && is_byte),
		.clear   (adv_s1 && is_start),
		.rx_byte (byte_s1),
		.active  (active_q),
		.evt     (evt)
	);

	// A notify acknowledge sends the chunk at the current offset; a chunk
	// acknowledge moves to the next one first. The file ends when the
	// offset reaches the file length.
	always_comb begin
		base_off = evt.chunk_ack ? next_off_q : offset_q;
		remain   = {2'b00, file_len_q} - {1'b0, base_off};
		past_end = remain[25] || (remain == 26'd0);
		if (past_end) begin
			len_calc = 8'd0;
		end else if (remain < 26'(CHUNK_BYTES)) begin
			len_calc = remain[7:0];
		end else begin
			len_calc = 8'(CHUNK_BYTES);
		end
	end

	always_comb begin
		emit   = 1'b0;
		act_d  = fdre_pkg::ACT_DROP;
		off_d  = '0;
		len_d  = '0;
		code_d = '0;
		unique case (cmd_s1)
			fdre_pkg::CMD_BYTE: begin
				priority if (evt.drop) begin
					emit = 1'b1;
				end else if (evt.crc_err) begin
					emit  = 1'b1;
					act_d = fdre_pkg::ACT_CRC_ERR;
				end else if (evt.dev_err) begin
					emit   = 1'b1;
					act_d  = fdre_pkg::ACT_DEV_ERR;
					code_d = evt.code;
				end else if (evt.chunk_ack && past_end) begin
					emit  = 1'b1;
					act_d = fdre_pkg::ACT_DONE;
				end else if (evt.notify_ack || evt.chunk_ack) begin
					emit  = 1'b1;
					act_d = fdre_pkg::ACT_CHUNK;
					off_d = base_off[23:0];
					len_d = len_calc;
				end else begin
					emit = 1'b0;
				end
			end
			fdre_pkg::CMD_TICK: begin
				emit  = armed_q;
				act_d = fdre_pkg::ACT_NOTIFY;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			file_len_q  <= '0;
			active_q    <= 1'b0;
			armed_q     <= 1'b0;
			offset_q    <= '0;
			next_off_q  <= 25'(CHUNK_BYTES);
		end else begin
			if (cfg_wr_en) begin
				file_len_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				unique case (cmd_s1)
					fdre_pkg::CMD_START: begin
						active_q   <= 1'b1;
						armed_q    <= 1'b1;
						offset_q   <= '0;
						next_off_q <= 25'(CHUNK_BYTES);
					end
					fdre_pkg::CMD_STOP: begin
						active_q <= 1'b0;
						armed_q  <= 1'b0;
					end
					fdre_pkg::CMD_BYTE: begin
						if (evt.notify_ack) begin
							armed_q <= 1'b0;
						end
						if (evt.chunk_ack) begin
							offset_q   <= next_off_q;
							next_off_q <= next_off_q + 25'(CHUNK_BYTES);
							if (past_end) begin
								active_q <= 1'b0;
								armed_q  <= 1'b0;
							end
						end
					end
					default: begin
						active_q <= active_q;
					end
				endcase
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ready) begin
			cmd_s1  <= command;
			byte_s1 <= byte_value;
		end
		if (adv_s1) begin
			action_q     <= act_d;
			offset_out_q <= off_d;
			length_q     <= len_d;
			code_q       <= code_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign chunk_offset = offset_out_q;
	assign chunk_length = length_q;
	assign device_code  = code_q;

	// A chunk never exceeds the configured chunk size.
	`AST_CLK_MSG(a_len_cap, out_valid |-> (chunk_length <= 8'(CHUNK_BYTES)), "chunk too long")
	// Only chunk results carry an offset and a length.
	`AST_CLK(a_nonchunk_zero, (out_valid && action != fdre_pkg::ACT_CHUNK) |-> (chunk_offset == 24'd0 && chunk_length == 8'd0))
	// Finishing the file stops the download and the retry timer.
	`AST_CLK(a_done_stops, (adv_s1 && is_byte && emit && act_d == fdre_pkg::ACT_DONE) |=> (!active_q && !armed_q))
	// The next offset stays one chunk ahead of the send offset.
	`AST_CLK(a_next_off, next_off_q == offset_q + 25'(CHUNK_BYTES))

endmodule

// ===== sim/file_download_response_engine_unit_tb.sv =====
// ---------------------------------------------------------------------------
// File download response engine testbench
// Drives received reply bytes and start, stop and retry-tick words into the
// engine, predicts every action from its own model of the reply receiver,
// and compares each output word field by field under random back-pressure.
// ---------------------------------------------------------------------------
module file_download_response_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHUNK_SIZE      = 240;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_WORDS     = 115;

	// One action word as the engine reports it.
	typedef struct packed {
		logic [2:0]  act;
		logic [23:0] off;
		logic [7:0]  len;
		logic [7:0]  code;
	} dl_action_t;

	// Modbus-RTU CRC16 update for one byte, bit by bit, LSB first.
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ fdre_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	// Bytes covered by the CRC for a reply command; the CRC follows them.
	function automatic int crc_span(input logic [7:0] op);
		case (op)
			fdre_pkg::FRM_NOTIFY_ACK: return 4;
			fdre_pkg::FRM_CHUNK_ACK:  return 9;
			default:                  return 3;
		endcase
	endfunction

	function automatic bit is_reply_cmd(input logic [7:0] op);
		return (op == fdre_pkg::FRM_NOTIFY_ACK) || (op == fdre_pkg::FRM_CHUNK_ACK) ||
			(op == fdre_pkg::FRM_ERR_A) || (op == fdre_pkg::FRM_ERR_B);
	endfunction

	// Keeps a private copy of the engine state, turns each accepted input
	// word into the action it should cause, and checks output words against
	// the oldest pending action.
	class action_scoreboard;
		logic [7:0]  frame_bytes[11];
		logic [3:0]  frame_len;
		logic [15:0] crc;
		bit          active;
		bit          armed;
		logic [24:0] offset;
		logic [23:0] file_len;
		dl_action_t  expected_actions[$];
		int          errors;

		function new();
			foreach (frame_bytes[i]) begin
				frame_bytes[i] = 8'h00;
			end
			frame_len = 4'd0;
			crc       = fdre_pkg::CRC_INIT;
			active    = 1'b0;
			armed     = 1'b0;
			offset    = 25'd0;
			file_len  = 24'd0;
			errors    = 0;
		endfunction

		function void set_file_length(input logic [23:0] v);
			file_len = v;
		endfunction

		function void restart_frame();
			frame_len = 4'd0;
			crc       = fdre_pkg::CRC_INIT;
		endfunction

		function void push_action(input logic [2:0] a, input logic [23:0] o,
				input logic [7:0] l, input logic [7:0] c);
			dl_action_t e;
			e.act  = a;
			e.off  = o;
			e.len  = l;
			e.code = c;
			expected_actions.push_back(e);
		endfunction

		// Next chunk at the current offset; nothing left to send gives length 0.
		function void push_chunk();
			logic [24:0] rem;
			logic [7:0]  l;
			l = 8'd0;
			if (offset < {1'b0, file_len}) begin
				rem = {1'b0, file_len} - offset;
				l   = (rem < CHUNK_SIZE) ? rem[7:0] : 8'(CHUNK_SIZE);
			end
			push_action(fdre_pkg::ACT_CHUNK, offset[23:0], l, 8'h00);
		endfunction

		function void take_byte(input logic [7:0] b);
			logic [3:0]  idx;
			logic [7:0]  op;
			logic [15:0] rx;
			int          span;
			idx = frame_len;
			if (idx == 4'd0 && b != fdre_pkg::FRM_ADDR) begin
				push_action(fdre_pkg::ACT_DROP, 24'd0, 8'd0, 8'd0);
				return;
			end
			if (idx >= fdre_pkg::FRM_MAX_BYTES) begin
				restart_frame();
				push_action(fdre_pkg::ACT_DROP, 24'd0, 8'd0, 8'd0);
				return;
			end
			frame_bytes[idx] = b;
			frame_len        = idx + 4'd1;
			if (idx < 2 || idx < crc_span(frame_bytes[1])) begin
				crc = crc_step(crc, b);
			end
			if (frame_len < fdre_pkg::FRM_MIN_CHECK) begin
				return;
			end
			op = frame_bytes[1];
			if (!is_reply_cmd(op) || !active) begin
				restart_frame();
				push_action(fdre_pkg::ACT_DROP, 24'd0, 8'd0, 8'd0);
				return;
			end
			span = crc_span(op);
			if (frame_len < span + 2) begin
				return;
			end
			rx = {frame_bytes[span + 1], frame_bytes[span]};
			restart_frame();
			if (rx != crc_hold(rx)) begin
				return;
			end
			if (op == fdre_pkg::FRM_NOTIFY_ACK) begin
				armed = 1'b0;
				push_chunk();
			end else if (op == fdre_pkg::FRM_CHUNK_ACK) begin
				offset = offset + 25'(CHUNK_SIZE);
				if (offset >= {1'b0, file_len}) begin
					active = 1'b0;
					armed  = 1'b0;
					push_action(fdre_pkg::ACT_DONE, 24'd0, 8'd0, 8'd0);
				end else begin
					push_chunk();
				end
			end else begin
				push_action(fdre_pkg::ACT_DEV_ERR, 24'd0, 8'd0, frame_bytes[2]);
			end
		endfunction

		// The CRC is compared after the frame restarts; this keeps the running
		// value of the finished frame around for that one comparison.
		logic [15:0] done_crc;

		function logic [15:0] crc_hold(input logic [15:0] rx);
			if (rx != done_crc) begin
				push_action(fdre_pkg::ACT_CRC_ERR, 24'd0, 8'd0, 8'd0);
			end
			return rx == done_crc ? rx : ~rx;
		endfunction

		function void note_word(input logic [1:0] cmd, input logic [7:0] b);
			case (cmd)
				fdre_pkg::CMD_BYTE: begin
					done_crc = crc_after(b);
					take_byte(b);
				end
				fdre_pkg::CMD_START: begin
					active = 1'b1;
					armed  = 1'b1;
					offset = 25'd0;
					restart_frame();
				end
				fdre_pkg::CMD_STOP: begin
					active = 1'b0;
					armed  = 1'b0;
				end
				default: begin
					if (armed) begin
						push_action(fdre_pkg::ACT_NOTIFY, 24'd0, 8'd0, 8'd0);
					end
				end
			endcase
		endfunction

		// Running CRC as it stands once this byte has been taken in.
		function logic [15:0] crc_after(input logic [7:0] b);
			logic [3:0] idx;
			idx = frame_len;
			if (idx >= 2 && idx >= crc_span(frame_bytes[1])) begin
				return crc;
			end
			return crc_step(crc, b);
		endfunction

		function void check_action(input logic [2:0] a, input logic [23:0] o,
				input logic [7:0] l, input logic [7:0] c);
			dl_action_t e;
			if (expected_actions.size() == 0) begin
				$error("unexpected output word: action %0d, offset %0d", a, o);
				errors++;
				return;
			end
			e = expected_actions.pop_front();
			if (a !== e.act) begin
				$error("action: expected %0d, got %0d", e.act, a);
				errors++;
			end
			if (o !== e.off) begin
				$error("chunk_offset: expected %0d, got %0d", e.off, o);
				errors++;
			end
			if (l !== e.len) begin
				$error("chunk_length: expected %0d, got %0d", e.len, l);
				errors++;
			end
			if (c !== e.code) begin
				$error("device_code: expected %0d, got %0d", e.code, c);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [23:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [7:0]  byte_value;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [23:0] chunk_offset;
	logic [7:0]  chunk_length;
	logic [7:0]  device_code;

	action_scoreboard sb;
	int               words_sent;
	int               cycle_count;
	int               tx_calm;
	int               rx_calm;
	int               rx_stall;
	bit               hold_off_req;

	file_download_response_engine_unit #(
		.CHUNK_BYTES(CHUNK_SIZE)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.byte_value   (byte_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.chunk_offset (chunk_offset),
		.chunk_length (chunk_length),
		.device_code  (device_code)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Gap length for either side of the link. Most gaps are zero or short, a
	// few are long, and now and then a calm stretch of back-to-back words is
	// forced so that full-rate operation gets exercised too.
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
		end
		if (r < 65) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offers one input word after a random gap and waits until the engine
	// takes it. Valid stays high after acceptance; the caller either offers
	// the next word at the following falling edge or lowers valid there.
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		command    <= cmd;
		byte_value <= b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_word(cmd, b);
		words_sent++;
	endtask

	// Builds one reply frame with a random body and a correct CRC. A corrupt
	// frame gets one bit flipped past the command byte; keep > 0 sends only
	// that many leading bytes, which leaves a partial frame behind.
	task automatic send_frame(input logic [7:0] op, input bit corrupt, input int keep);
		logic [7:0]  fr[$];
		logic [15:0] c;
		int          span;
		int          idx;
		int          n;
		fr.push_back(fdre_pkg::FRM_ADDR);
		fr.push_back(op);
		span = crc_span(op);
		while (fr.size() < span) begin
			fr.push_back(8'($urandom_range(0, 255)));
		end
		c = fdre_pkg::CRC_INIT;
		foreach (fr[i]) begin
			c = crc_step(c, fr[i]);
		end
		fr.push_back(c[7:0]);
		fr.push_back(c[15:8]);
		if (corrupt) begin
			idx     = $urandom_range(2, fr.size() - 1);
			fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
		end
		n = (keep > 0 && keep < fr.size()) ? keep : fr.size();
		for (int i = 0; i < n; i++) begin
			send_word(fdre_pkg::CMD_BYTE, fr[i]);
		end
	endtask

	function automatic logic [7:0] any_reply_cmd();
		case ($urandom_range(0, 3))
			0:       return fdre_pkg::FRM_NOTIFY_ACK;
			1:       return fdre_pkg::FRM_CHUNK_ACK;
			2:       return fdre_pkg::FRM_ERR_A;
			default: return fdre_pkg::FRM_ERR_B;
		endcase
	endfunction

	// One random stretch of traffic. Most of it is well-formed download
	// traffic (start, ticks, acknowledges, device errors, stops) with random content;
	// the rest is corrupted frames, unknown commands, cut-off frames and noise.
	task automatic random_sequence();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			send_word(fdre_pkg::CMD_START, 8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 2))
				send_word(fdre_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		end else if (r < 14) begin
			send_word(fdre_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
		end else if (r < 34) begin
			send_frame(fdre_pkg::FRM_NOTIFY_ACK, 1'b0, 0);
		end else if (r < 58) begin
			send_frame(fdre_pkg::FRM_CHUNK_ACK, 1'b0, 0);
		end else if (r < 68) begin
			send_frame($urandom_range(0, 1) ? fdre_pkg::FRM_ERR_A : fdre_pkg::FRM_ERR_B,
				1'b0, 0);
		end else if (r < 76) begin
			send_frame(any_reply_cmd(), 1'b1, 0);
		end else if (r < 82) begin
			// Address, then an arbitrary command byte and three more bytes.
			send_word(fdre_pkg::CMD_BYTE, fdre_pkg::FRM_ADDR);
			repeat (4) send_word(fdre_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
		end else if (r < 89) begin
			repeat ($urandom_range(1, 3))
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end else if (r < 93) begin
			send_word(fdre_pkg::CMD_STOP, 8'($urandom_range(0, 255)));
		end else begin
			send_frame(any_reply_cmd(), 1'b0, $urandom_range(1, 4));
		end
	endtask

	// Brings the engine to rest: valid drops, every pending action arrives,
	// and a further drain wait lets words with no result clear the pipeline.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_actions.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_file_length(input logic [23:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		sb.set_file_length(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver side: random ready gaps, plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps pushing words and the
	// engine fills up and stalls its input.
	initial begin
		out_ready = 1'b0;
		rx_calm   = 0;
		rx_stall  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (rx_stall > 0) begin
				out_ready <= 1'b0;
				rx_stall--;
			end else begin
				out_ready <= 1'b1;
				rx_stall = pick_gap(rx_calm);
			end
		end
	end

	// Output monitor: every accepted output word is checked against the
	// oldest pending action.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_action(action, chunk_offset, chunk_length, device_code);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [23:0] lengths[8];
		sb           = new();
		words_sent   = 0;
		cycle_count  = 0;
		tx_calm      = 0;
		hold_off_req = 1'b0;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = 24'd0;
		in_valid     = 1'b0;
		command      = fdre_pkg::CMD_BYTE;
		byte_value   = 8'h00;

		// Reset is held from the start and released between edges.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: a one-chunk file walked through its whole life.
		// A tick before any start must stay silent, a tick while armed asks
		// for a notify, a wrong first byte is dropped, the notify ack asks for
		// the first chunk, a device error frame reports its code, and the
		// chunk ack completes the file. Stop closes it.
		settle();
		write_file_length(24'd240);
		send_word(fdre_pkg::CMD_TICK, 8'hFF);
		send_word(fdre_pkg::CMD_START, 8'h00);
		send_word(fdre_pkg::CMD_TICK, 8'h00);
		send_word(fdre_pkg::CMD_BYTE, 8'hFF);
		send_frame(fdre_pkg::FRM_NOTIFY_ACK, 1'b0, 0);
		send_frame(fdre_pkg::FRM_ERR_B, 1'b0, 0);
		send_frame(fdre_pkg::FRM_CHUNK_ACK, 1'b0, 0);
		send_word(fdre_pkg::CMD_STOP, 8'hFF);

		// Random phases, each with its own file length, the extremes included:
		// an empty file, the largest one, one byte, just past a chunk, exactly one
		// chunk, and three random sizes.
		lengths[0] = 24'd0;
		lengths[1] = 24'hFFFFFF;
		lengths[2] = 24'd1;
		lengths[3] = 24'd241;
		lengths[4] = 24'(480 + $urandom_range(0, 960));
		lengths[5] = 24'($urandom_range(1, 2000));
		lengths[6] = 24'($urandom_range(0, 24'hFFFFFF));
		lengths[7] = 24'd240;
		foreach (lengths[p]) begin
			int target;
			settle();
			write_file_length(lengths[p]);
			// The fourth phase runs with the receiver held off for a while.
			if (p == 3) begin
				hold_off_req = 1'b1;
			end
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				random_sequence();
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/fdre_pkg.sv
src/fdre_frame_rx.sv
src/file_download_response_engine_unit.sv
sim/file_download_response_engine_unit_tb.sv
